// ===== hdl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Banner and chunk deframer package
// Shared item types, result kinds and framing constants.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int BANNER_BYTES = 24;
    localparam int IDX_W        = 5;
    localparam int LEN_W        = 32;
    localparam int MAX_W        = 27;

    localparam logic [IDX_W-1:0] BANNER_LAST   = IDX_W'(BANNER_BYTES - 1);
    localparam logic [IDX_W-1:0] WIDTH_OFFSET  = IDX_W'(14);
    localparam logic [IDX_W-1:0] HEIGHT_OFFSET = IDX_W'(18);
    localparam logic [LEN_W-1:0] ROTATION_LEN  = LEN_W'(4);
    localparam logic [MAX_W-1:0] MAX_CHUNK_RESET = MAX_W'(64 * 1024 * 1024);

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_SIZE    = 2'd1;
    localparam logic [1:0] KIND_BAD_LEN = 2'd2;

    typedef enum logic [3:0] {
        PH_BANNER  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_ROTATE  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         payload_byte;
        logic               last_of_chunk;
        logic signed [31:0] device_width;
        logic signed [31:0] device_height;
        logic signed [31:0] bad_length;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic res_valid;
    } t_step_ctl;

endpackage

// ===== hdl/banner_and_chunk_deframer.sv =====
// ----------------------------------------------------------------------------
// Banner and chunk deframer
// Takes a byte stream one beat at a time, captures the device size from the
// banner, then splits the stream into length-prefixed chunks.
//
// The input channel carries one stream byte and a restart flag per beat. The
// output channel carries one result beat: a payload byte with its end mark, a
// device size report, or a rejected chunk length. Many input beats give no
// result. The configuration channel writes the largest accepted chunk length
// and is always ready.
// Each input beat is registered, decoded combinationally and its result is
// registered, so a result passes the input register, then the result register.
// One beat is accepted per clock as long as the result register drains.
// When the receiver stalls, the result register holds; beats that produce no
// result still pass, and the input register fills once a result is blocked.
// Reset returns the parser to banner capture, empties both registers and sets
// the chunk limit to 64 MiB. A restart beat resets only the parser state.
// ----------------------------------------------------------------------------
module banner_and_chunk_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bcd_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bcd_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcd_pkg::MAX_W-1:0]     i_cfg_data
);

    logic               w_in_vld;
    bcd_pkg::t_in_item  w_in_item;
    logic               w_out_free;
    bcd_pkg::t_step_ctl w_ctl;
    bcd_pkg::t_out_item w_res;

    assign o_cfg_ready = 1'b1;

    bcd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_take     (w_ctl.take),
        .o_vld      (w_in_vld),
        .o_item     (w_in_item)
    );

    bcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_vld       (w_in_vld),
        .i_item      (w_in_item),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl),
        .o_res       (w_res)
    );

    bcd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.res_valid |-> w_out_free)
        else $error("result loaded while the result register is blocked");

    a_take_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.take |-> w_in_vld)
        else $error("parser consumed an empty input register");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_vld && !w_ctl.take |=> w_in_vld && $stable(w_in_item))
        else $error("unconsumed input beat lost");

    a_size_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != bcd_pkg::KIND_SIZE |->
            o_out_data.device_width == 32'sd0 && o_out_data.device_height == 32'sd0)
        else $error("size fields set on a non-size result");

endmodule

// ===== hdl/bcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted stream beat until the parser consumes it.
// ----------------------------------------------------------------------------
module bcd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bcd_pkg::t_in_item i_in_data,
    input  logic              i_take,
    output logic              o_vld,
    output bcd_pkg::t_in_item o_item
);

    logic              r_vld;
    bcd_pkg::t_in_item r_item;

    assign o_in_ready = !r_vld || i_take;
    assign o_vld      = r_vld;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

endmodule

// ===== hdl/bcd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Banner capture, length header decode, rotation skip and payload count.
// ----------------------------------------------------------------------------
module bcd_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bcd_pkg::MAX_W-1:0]           i_cfg_data,
    input  logic                                i_vld,
    input  bcd_pkg::t_in_item                   i_item,
    input  logic                                i_out_free,
    output bcd_pkg::t_step_ctl                  o_ctl,
    output bcd_pkg::t_out_item                  o_res
);

    bcd_pkg::t_phase                 r_phase, n_phase;
    logic [bcd_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [bcd_pkg::LEN_W-1:0]       r_len, n_len;
    logic [bcd_pkg::MAX_W-1:0]       r_rem, n_rem;
    logic [31:0]                     r_width, n_width;
    logic [31:0]                     r_height, n_height;
    logic [bcd_pkg::MAX_W-1:0]       r_max;
    logic [bcd_pkg::IDX_W-1:0]       w_wsel, w_hsel;
    logic [bcd_pkg::LEN_W-1:0]       w_len_full;
    logic [bcd_pkg::MAX_W-1:0]       w_rem_dec;
    logic                            w_has_res;
    logic                            w_take;
    bcd_pkg::t_out_item              w_res;

    assign w_wsel    = r_idx - bcd_pkg::WIDTH_OFFSET;
    assign w_hsel    = r_idx - bcd_pkg::HEIGHT_OFFSET;
    assign w_rem_dec = r_rem - bcd_pkg::MAX_W'(1);

    always_comb begin
        w_len_full = r_len;
        w_len_full[{r_idx[1:0], 3'b000} +: 8] = i_item.stream_byte;
    end

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_len     = r_len;
        n_rem     = r_rem;
        n_width   = r_width;
        n_height  = r_height;
        w_has_res = 1'b0;
        w_res     = '0;
        if (i_item.restart) begin
            n_phase  = bcd_pkg::PH_BANNER;
            n_idx    = '0;
            n_len    = '0;
            n_rem    = '0;
            n_width  = '0;
            n_height = '0;
        end else begin
            unique case (r_phase)
                bcd_pkg::PH_BANNER: begin
                    if (r_idx >= bcd_pkg::WIDTH_OFFSET && r_idx < bcd_pkg::HEIGHT_OFFSET) begin
                        n_width[{w_wsel[1:0], 3'b000} +: 8] = i_item.stream_byte;
                    end else if (r_idx >= bcd_pkg::HEIGHT_OFFSET &&
                                 r_idx < bcd_pkg::HEIGHT_OFFSET + bcd_pkg::IDX_W'(4)) begin
                        n_height[{w_hsel[1:0], 3'b000} +: 8] = i_item.stream_byte;
                    end
                    if (r_idx >= bcd_pkg::BANNER_LAST) begin
                        n_phase             = bcd_pkg::PH_LENGTH;
                        n_idx               = '0;
                        n_len               = '0;
                        w_has_res           = 1'b1;
                        w_res.kind          = bcd_pkg::KIND_SIZE;
                        w_res.device_width  = n_width;
                        w_res.device_height = n_height;
                    end else begin
                        n_idx = r_idx + bcd_pkg::IDX_W'(1);
                    end
                end
                bcd_pkg::PH_LENGTH: begin
                    n_len = w_len_full;
                    if (r_idx[1:0] != 2'd3) begin
                        n_idx = r_idx + bcd_pkg::IDX_W'(1);
                    end else begin
                        n_idx = '0;
                        n_len = '0;
                        if (w_len_full == bcd_pkg::ROTATION_LEN) begin
                            n_phase = bcd_pkg::PH_ROTATE;
                            n_len   = w_len_full;
                        end else if (w_len_full == '0 || w_len_full[bcd_pkg::LEN_W-1] ||
                                     w_len_full > {5'd0, r_max}) begin
                            w_has_res        = 1'b1;
                            w_res.kind       = bcd_pkg::KIND_BAD_LEN;
                            w_res.bad_length = w_len_full;
                        end else begin
                            n_rem   = w_len_full[bcd_pkg::MAX_W-1:0];
                            n_phase = bcd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                bcd_pkg::PH_ROTATE: begin
                    if (r_idx[1:0] == 2'd3) begin
                        n_idx   = '0;
                        n_phase = bcd_pkg::PH_LENGTH;
                    end else begin
                        n_idx = r_idx + bcd_pkg::IDX_W'(1);
                    end
                end
                bcd_pkg::PH_PAYLOAD: begin
                    n_rem               = w_rem_dec;
                    w_has_res           = 1'b1;
                    w_res.kind          = bcd_pkg::KIND_PAYLOAD;
                    w_res.payload_byte  = i_item.stream_byte;
                    w_res.last_of_chunk = (w_rem_dec == '0);
                    if (w_rem_dec == '0) begin
                        n_phase = bcd_pkg::PH_LENGTH;
                        n_idx   = '0;
                    end
                end
                default: begin
                    n_phase = bcd_pkg::PH_BANNER;
                    n_idx   = '0;
                end
            endcase
        end
    end

    assign w_take          = i_vld && (i_out_free || !w_has_res);
    assign o_ctl.take      = w_take;
    assign o_ctl.res_valid = w_take && w_has_res;
    assign o_res           = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bcd_pkg::PH_BANNER;
            r_idx    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (w_take) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= bcd_pkg::MAX_CHUNK_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

endmodule

// ===== hdl/bcd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module bcd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcd_pkg::t_step_ctl  i_ctl,
    input  bcd_pkg::t_out_item  i_res,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bcd_pkg::t_out_item  o_out_data
);

    logic               r_vld;
    bcd_pkg::t_out_item r_res;

    assign o_free      = !r_vld || i_out_ready;
    assign o_out_valid = r_vld;
    assign o_out_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.res_valid) begin
            r_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_valid) begin
            r_res <= i_res;
        end
    end

endmodule
